// ----- design/cvp_pkg.sv -----
// Shared types, constants and codes for the cascaded PID motor controller.
`default_nettype none

package cvp_pkg;

  localparam int DATA_W    = 16;
  localparam int ERR_W     = 17;
  localparam int DIFF_W    = 18;
  localparam int INT_W     = 17;
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 15;
  localparam int PROD_W    = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W     = 36;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int MODE_W    = 2;

  localparam int DEF_ANGLE_DEAD_BAND = 0;
  localparam int DEF_ANGLE_INT_LIMIT = 16384;
  localparam int DEF_SPEED_INT_LIMIT = 16384;
  localparam int DEF_GAIN_FRAC_BITS  = 8;

  localparam logic [MODE_W-1:0] MODE_OPEN    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPEED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CASCADE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KI  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_KD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KI  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_KD  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DRIVE = 3'd7;

  typedef struct packed {
    logic [MODE_W-1:0] loop_mode;
    logic [GAIN_W-1:0] speed_kp;
    logic [GAIN_W-1:0] speed_ki;
    logic [GAIN_W-1:0] speed_kd;
    logic [GAIN_W-1:0] angle_kp;
    logic [GAIN_W-1:0] angle_ki;
    logic [GAIN_W-1:0] angle_kd;
    logic [LIM_W-1:0]  max_drive;
  } cfg_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_CLAMP,
    ACC_SAT16
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } mac_ctrl_t;

endpackage

`default_nettype wire

// ----- design/cvp_if.sv -----
// Valid/ready channel interfaces for control tick items and drive result items.
`default_nettype none

interface cvp_in_if import cvp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] target_speed;
  logic signed [DATA_W-1:0] measured_speed;
  logic signed [DATA_W-1:0] target_angle;
  logic signed [DATA_W-1:0] measured_angle;
  logic signed [DATA_W-1:0] manual_drive;

  modport source (output valid, target_speed, measured_speed, target_angle,
                  measured_angle, manual_drive, input ready);
  modport sink (input valid, target_speed, measured_speed, target_angle,
                measured_angle, manual_drive, output ready);
endinterface

interface cvp_out_if import cvp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic signed [DATA_W-1:0] inner_setpoint;

  modport source (output valid, drive, inner_setpoint, input ready);
  modport sink (input valid, drive, inner_setpoint, output ready);
endinterface

`default_nettype wire

// ----- design/cascaded_pid_motor_controller.sv -----
// Top level of the cascaded angle and speed PID motor controller.
`default_nettype none

// Each accepted item is one control tick. In open loop (loop_mode 0 or 3) the
// manual drive is returned in the cycle after acceptance with an inner setpoint
// of zero. In speed mode only the speed loop runs; in cascade mode the angle
// loop runs first and its result becomes the speed setpoint. Both loops run
// their integral, proportional and derivative products one after another
// through a single shared multiply-accumulate unit, eight sequencer steps per
// loop. The block accepts a new item only when the sequencer is idle, so it
// cannot take a new item while a closed-loop item is still in its steps. A
// finished result waits in the output register and a new item may be
// accepted in the cycle that result is taken.
module cascaded_pid_motor_controller import cvp_pkg::*; #(
  parameter int ANGLE_DEAD_BAND = DEF_ANGLE_DEAD_BAND,
  parameter int ANGLE_INT_LIMIT = DEF_ANGLE_INT_LIMIT,
  parameter int SPEED_INT_LIMIT = DEF_SPEED_INT_LIMIT,
  parameter int GAIN_FRAC_BITS  = DEF_GAIN_FRAC_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  cvp_in_if.sink                    in_ch,
  cvp_out_if.source                 out_ch
);

  localparam logic [LIM_W-1:0] ANG_LIM = LIM_W'(ANGLE_INT_LIMIT);
  localparam logic [LIM_W-1:0] SPD_LIM = LIM_W'(SPEED_INT_LIMIT);
  localparam logic [ERR_W:0]   ANG_ZERO_BAND = (ERR_W + 1)'(ANGLE_DEAD_BAND);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_MUL_I,
    S_ACC_I,
    S_CLAMP_I,
    S_ADD_P,
    S_ADD_D,
    S_LIMIT,
    S_DONE
  } state_t;

  cfg_t                     cfg;
  state_t                   state;
  logic                     is_angle;
  logic signed [DATA_W-1:0] setp;
  logic signed [DATA_W-1:0] m_spd;
  logic signed [DATA_W-1:0] t_ang;
  logic signed [DATA_W-1:0] m_ang;
  logic signed [ERR_W-1:0]  err;
  logic signed [ERR_W-1:0]  spd_prev;
  logic signed [ERR_W-1:0]  ang_prev;
  logic signed [INT_W-1:0]  spd_int;
  logic signed [INT_W-1:0]  ang_int;
  logic                     out_valid;
  logic signed [DATA_W-1:0] drive_q;
  logic signed [DATA_W-1:0] setp_q;

  logic                     closed_loop;
  logic                     in_take;
  logic signed [ERR_W-1:0]  ang_err;
  logic [ERR_W-1:0]         ang_mag;
  logic signed [ERR_W-1:0]  spd_err;
  logic signed [ERR_W-1:0]  cur_prev;
  logic signed [DIFF_W-1:0] err_diff;
  mac_ctrl_t                mac_ctrl;
  logic [GAIN_W-1:0]        mac_gain;
  logic signed [DIFF_W-1:0] mac_operand;
  logic signed [INT_W-1:0]  mac_base;
  logic [LIM_W-1:0]         mac_lim;
  logic signed [ACC_W-1:0]  acc;

  cvp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cvp_mac #(
    .FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .gain    (mac_gain),
    .operand (mac_operand),
    .base    (mac_base),
    .lim     (mac_lim),
    .acc     (acc)
  );

  assign closed_loop  = (cfg.loop_mode == MODE_SPEED) || (cfg.loop_mode == MODE_CASCADE);
  assign in_ch.ready  = (state == S_IDLE) && (!out_valid || out_ch.ready);
  assign in_take      = in_ch.valid && in_ch.ready;

  assign out_ch.valid          = out_valid;
  assign out_ch.drive          = drive_q;
  assign out_ch.inner_setpoint = setp_q;

  assign ang_err  = {t_ang[DATA_W-1], t_ang} - {m_ang[DATA_W-1], m_ang};
  assign ang_mag  = ang_err[ERR_W-1] ? ERR_W'(-ang_err) : ang_err;
  assign spd_err  = {setp[DATA_W-1], setp} - {m_spd[DATA_W-1], m_spd};
  assign cur_prev = is_angle ? ang_prev : spd_prev;
  assign err_diff = {err[ERR_W-1], err} - {cur_prev[ERR_W-1], cur_prev};

  always_comb begin
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = ACC_HOLD;
    mac_gain        = is_angle ? cfg.angle_ki : cfg.speed_ki;
    mac_operand     = {err[ERR_W-1], err};
    mac_base        = is_angle ? ang_int : spd_int;
    mac_lim         = is_angle ? ANG_LIM : SPD_LIM;
    case (state)
      S_MUL_I: begin
        mac_ctrl.mul_en = 1'b1;
      end
      S_ACC_I: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_LOAD;
        mac_gain        = is_angle ? cfg.angle_kp : cfg.speed_kp;
      end
      S_CLAMP_I: begin
        mac_ctrl.acc_op = ACC_CLAMP;
      end
      S_ADD_P: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_ADD;
        mac_gain        = is_angle ? cfg.angle_kd : cfg.speed_kd;
        mac_operand     = err_diff;
      end
      S_ADD_D: begin
        mac_ctrl.acc_op = ACC_ADD;
      end
      S_LIMIT: begin
        mac_ctrl.acc_op = is_angle ? ACC_SAT16 : ACC_CLAMP;
        mac_lim         = cfg.max_drive;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      is_angle  <= 1'b0;
      out_valid <= 1'b0;
      spd_prev  <= '0;
      ang_prev  <= '0;
      spd_int   <= '0;
      ang_int   <= '0;
    end else begin
      if (out_valid && out_ch.ready && !(in_take && !closed_loop)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            m_spd <= in_ch.measured_speed;
            t_ang <= in_ch.target_angle;
            m_ang <= in_ch.measured_angle;
            setp  <= in_ch.target_speed;
            if (closed_loop) begin
              is_angle <= (cfg.loop_mode == MODE_CASCADE);
              state    <= S_ERR;
            end else begin
              drive_q   <= in_ch.manual_drive;
              setp_q    <= '0;
              out_valid <= 1'b1;
            end
          end
        end
        S_ERR: begin
          if (is_angle) begin
            err <= ({1'b0, ang_mag} < ANG_ZERO_BAND) ? '0 : ang_err;
          end else begin
            err <= spd_err;
          end
          state <= S_MUL_I;
        end
        S_MUL_I:   state <= S_ACC_I;
        S_ACC_I:   state <= S_CLAMP_I;
        S_CLAMP_I: state <= S_ADD_P;
        S_ADD_P: begin
          if (is_angle) begin
            ang_int <= acc[INT_W-1:0];
          end else begin
            spd_int <= acc[INT_W-1:0];
          end
          state <= S_ADD_D;
        end
        S_ADD_D: begin
          if (is_angle) begin
            ang_prev <= err;
          end else begin
            spd_prev <= err;
          end
          state <= S_LIMIT;
        end
        S_LIMIT:   state <= S_DONE;
        S_DONE: begin
          if (is_angle) begin
            setp     <= acc[DATA_W-1:0];
            is_angle <= 1'b0;
            state    <= S_ERR;
          end else begin
            drive_q   <= acc[DATA_W-1:0];
            setp_q    <= setp;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default:   state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_drive_limited: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && closed_loop |->
      ($signed(out_ch.drive) <= $signed({1'b0, cfg.max_drive})) &&
      ($signed(out_ch.drive) >= -$signed({1'b0, cfg.max_drive})))
    else $error("Closed-loop drive exceeds the configured limit.");

  a_open_setpoint: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !closed_loop |-> out_ch.inner_setpoint == '0)
    else $error("Open-loop result carries a non-zero inner setpoint.");

  a_speed_int_bound: assert property (@(posedge clk) disable iff (rst)
    ($signed(spd_int) <= $signed({2'b00, SPD_LIM})) &&
    ($signed(spd_int) >= -$signed({2'b00, SPD_LIM})))
    else $error("Speed integral outside its clamp.");

  a_angle_int_bound: assert property (@(posedge clk) disable iff (rst)
    ($signed(ang_int) <= $signed({2'b00, ANG_LIM})) &&
    ($signed(ang_int) >= -$signed({2'b00, ANG_LIM})))
    else $error("Angle integral outside its clamp.");
`endif

endmodule

`default_nettype wire

// ----- design/cvp_cfg_regs.sv -----
// Configuration register bank for loop mode, gains and drive limit.
`default_nettype none

module cvp_cfg_regs import cvp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LOOP_MODE: cfg.loop_mode <= cfg_data[MODE_W-1:0];
        REG_SPEED_KP:  cfg.speed_kp  <= cfg_data[GAIN_W-1:0];
        REG_SPEED_KI:  cfg.speed_ki  <= cfg_data[GAIN_W-1:0];
        REG_SPEED_KD:  cfg.speed_kd  <= cfg_data[GAIN_W-1:0];
        REG_ANGLE_KP:  cfg.angle_kp  <= cfg_data[GAIN_W-1:0];
        REG_ANGLE_KI:  cfg.angle_ki  <= cfg_data[GAIN_W-1:0];
        REG_ANGLE_KD:  cfg.angle_kd  <= cfg_data[GAIN_W-1:0];
        REG_MAX_DRIVE: cfg.max_drive <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/cvp_mac.sv -----
// Shared multiply, accumulate and clamp unit used by both PID loops.
`default_nettype none

module cvp_mac import cvp_pkg::*; #(
  parameter int FRAC_BITS = DEF_GAIN_FRAC_BITS
) (
  input  wire logic                     clk,
  input  wire mac_ctrl_t                ctrl,
  input  wire logic [GAIN_W-1:0]        gain,
  input  wire logic signed [DIFF_W-1:0] operand,
  input  wire logic signed [INT_W-1:0]  base,
  input  wire logic [LIM_W-1:0]         lim,
  output logic signed [ACC_W-1:0]       acc
);

  localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] S16_MIN = -ACC_W'(32768);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] shifted;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  base_ext;
  logic signed [ACC_W-1:0]  lim_pos;
  logic signed [ACC_W-1:0]  lim_neg;
  logic signed [ACC_W-1:0]  acc_next;

  assign prod_next = $signed({1'b0, gain}) * operand;
  assign shifted   = prod >>> FRAC_BITS;
  assign term      = {{(ACC_W-PROD_W){shifted[PROD_W-1]}}, shifted};
  assign base_ext  = {{(ACC_W-INT_W){base[INT_W-1]}}, base};
  assign lim_pos   = $signed({{(ACC_W-LIM_W){1'b0}}, lim});
  assign lim_neg   = -lim_pos;

  always_comb begin
    acc_next = acc;
    case (ctrl.acc_op)
      ACC_HOLD:  acc_next = acc;
      ACC_LOAD:  acc_next = base_ext + term;
      ACC_ADD:   acc_next = acc + term;
      ACC_CLAMP: begin
        if (acc > lim_pos) begin
          acc_next = lim_pos;
        end else if (acc < lim_neg) begin
          acc_next = lim_neg;
        end
      end
      ACC_SAT16: begin
        if (acc > S16_MAX) begin
          acc_next = S16_MAX;
        end else if (acc < S16_MIN) begin
          acc_next = S16_MIN;
        end
      end
      default:   acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= prod_next;
    end
    acc <= acc_next;
  end

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the cascaded angle and speed PID motor controller.

module tb;
  import cvp_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASES          = 12;
  localparam int TICKS_PER_PHASE = 104;
  localparam int DIR_ROWS        = 21;

  typedef struct packed {
    logic signed [DATA_W-1:0] target_speed, measured_speed, target_angle, measured_angle;
    logic signed [DATA_W-1:0] manual_drive;
  } tick_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive, inner_setpoint;
  } drive_cmd_t;

  typedef struct packed {
    logic [2:0] cfg_sel;
    tick_t      tick;
    logic       known;
    drive_cmd_t cmd;
  } tick_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  cvp_in_if  in_ch ();
  cvp_out_if out_ch ();

  cascaded_pid_motor_controller u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  cfg_t       ctl_cfg;
  longint     spd_prev_err, spd_integ, ang_prev_err, ang_integ;
  drive_cmd_t pending_cmds [$];
  int         fail_count = 0;
  int         cycle_count = 0;
  bit         steady = 1'b0;
  bit         hold_req = 1'b0;

  cfg_t dir_cfgs [6] = '{
    '{MODE_OPEN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0},
    '{MODE_UNUSED, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0},
    '{MODE_SPEED, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0},
    '{MODE_SPEED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF},
    '{MODE_CASCADE, 16'd256, 16'd16, 16'd64, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF},
    '{MODE_CASCADE, 16'd300, 16'd20, 16'd50, 16'd512, 16'd32, 16'd128, 15'd1000}
  };

  // Open-loop rows and gainless speed rows carry their result; the rest are predicted.
  tick_row_t dir_rows [DIR_ROWS] = '{
    '{3'd0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd0}},
    '{3'd0, '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b1,
      '{16'sh7FFF, 16'sd0}},
    '{3'd0, '{16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b1,
      '{16'sh8000, 16'sd0}},
    '{3'd0, '{16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'sd1}, 1'b1, '{16'sd1, 16'sd0}},
    '{3'd1, '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, -16'sd1}, 1'b1,
      '{-16'sd1, 16'sd0}},
    '{3'd1, '{16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555}, 1'b1,
      '{16'sh5555, 16'sd0}},
    '{3'd2, '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sh7FFF}},
    '{3'd2, '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd9}, 1'b1, '{16'sd0, 16'sh8000}},
    '{3'd2, '{16'sd123, -16'sd7, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'sd0, 16'sd123}},
    '{3'd3, '{16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd3, '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd3, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd3, '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd3, '{-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd4, '{16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd4, '{16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd4, '{16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd4, '{16'sd0, 16'sd0, 16'sd5, 16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd5, '{16'sd0, 16'sd100, 16'sd1000, 16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd5, '{16'sd0, -16'sd50, -16'sd1000, -16'sd200, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}},
    '{3'd5, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '{16'sd0, 16'sd0}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint pid_step(input longint err, inout longint prev,
                                      inout longint integ,
                                      input logic [GAIN_W-1:0] kp, ki, kd,
                                      input longint lim);
    longint sum;
    longint outv;
    sum = integ + ((longint'(ki) * err) >>> DEF_GAIN_FRAC_BITS);
    if (sum < -lim) sum = -lim;
    else if (sum > lim) sum = lim;
    integ = sum;
    outv = ((longint'(kp) * err) >>> DEF_GAIN_FRAC_BITS) + sum
         + ((longint'(kd) * (err - prev)) >>> DEF_GAIN_FRAC_BITS);
    prev = err;
    return outv;
  endfunction

  function automatic drive_cmd_t predict_drive(input tick_t t);
    longint     aerr, setp, drv, lim;
    drive_cmd_t r;
    if (ctl_cfg.loop_mode == MODE_SPEED || ctl_cfg.loop_mode == MODE_CASCADE) begin
      lim = longint'(ctl_cfg.max_drive);
      if (ctl_cfg.loop_mode == MODE_CASCADE) begin
        aerr = longint'(t.target_angle) - longint'(t.measured_angle);
        if ((aerr < 0 ? -aerr : aerr) < DEF_ANGLE_DEAD_BAND) aerr = 0;
        setp = pid_step(aerr, ang_prev_err, ang_integ, ctl_cfg.angle_kp, ctl_cfg.angle_ki,
                        ctl_cfg.angle_kd, DEF_ANGLE_INT_LIMIT);
        if (setp < -32768) setp = -32768;
        else if (setp > 32767) setp = 32767;
      end else begin
        setp = longint'(t.target_speed);
      end
      drv = pid_step(setp - longint'(t.measured_speed), spd_prev_err, spd_integ,
                     ctl_cfg.speed_kp, ctl_cfg.speed_ki, ctl_cfg.speed_kd,
                     DEF_SPEED_INT_LIMIT);
      if (drv < -lim) drv = -lim;
      else if (drv > lim) drv = lim;
    end else begin
      drv = longint'(t.manual_drive);
      setp = 0;
    end
    r.drive = drv[DATA_W-1:0];
    r.inner_setpoint = setp[DATA_W-1:0];
    return r;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(3))
      0: return GAIN_W'($urandom_range(255));
      1: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(2047, 256));
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    int   pick;
    pick = $urandom_range(9);
    if (pick == 0) c.loop_mode = MODE_OPEN;
    else if (pick == 1) c.loop_mode = MODE_UNUSED;
    else if (pick < 6) c.loop_mode = MODE_SPEED;
    else c.loop_mode = MODE_CASCADE;
    c.speed_kp = random_gain();
    c.speed_ki = random_gain();
    c.speed_kd = random_gain();
    c.angle_kp = random_gain();
    c.angle_ki = random_gain();
    c.angle_kd = random_gain();
    case ($urandom_range(5))
      0: c.max_drive = '0;
      1: c.max_drive = '1;
      default: c.max_drive = LIM_W'($urandom);
    endcase
    return c;
  endfunction

  // Mostly plausible control ticks near the operating point, with some wild ones.
  function automatic tick_t random_tick();
    tick_t t;
    int    base_s, base_a;
    if ($urandom_range(4) == 0) begin
      t.target_speed   = DATA_W'($urandom);
      t.measured_speed = DATA_W'($urandom);
      t.target_angle   = DATA_W'($urandom);
      t.measured_angle = DATA_W'($urandom);
    end else begin
      base_s = int'($urandom_range(4000)) - 2000;
      base_a = int'($urandom_range(20000)) - 10000;
      t.target_speed   = DATA_W'(base_s);
      t.measured_speed = DATA_W'(base_s + int'($urandom_range(512)) - 256);
      t.target_angle   = DATA_W'(base_a);
      t.measured_angle = DATA_W'(base_a + int'($urandom_range(200)) - 100);
    end
    t.manual_drive = DATA_W'($urandom);
    return t;
  endfunction

  task automatic note_fault(input string what, input drive_cmd_t want, input drive_cmd_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0d: %s: expected drive %0d setpoint %0d, got drive %0d setpoint %0d",
               cycle_count, what, want.drive, want.inner_setpoint, got.drive,
               got.inner_setpoint);
  endtask

  task automatic reconfigure(input cfg_t c);
    logic [CFG_W-1:0] vals [8];
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    vals[REG_LOOP_MODE] = CFG_W'(c.loop_mode);
    vals[REG_SPEED_KP]  = c.speed_kp;
    vals[REG_SPEED_KI]  = c.speed_ki;
    vals[REG_SPEED_KD]  = c.speed_kd;
    vals[REG_ANGLE_KP]  = c.angle_kp;
    vals[REG_ANGLE_KI]  = c.angle_ki;
    vals[REG_ANGLE_KD]  = c.angle_kd;
    vals[REG_MAX_DRIVE] = CFG_W'(c.max_drive);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_write <= 1'b0;
    ctl_cfg = c;
  endtask

  task automatic send_tick(input tick_t t, input logic known, input drive_cmd_t cmd);
    drive_cmd_t predicted;
    in_ch.valid          <= 1'b1;
    in_ch.target_speed   <= t.target_speed;
    in_ch.measured_speed <= t.measured_speed;
    in_ch.target_angle   <= t.target_angle;
    in_ch.measured_angle <= t.measured_angle;
    in_ch.manual_drive   <= t.manual_drive;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_drive(t);
    pending_cmds.push_back(known ? cmd : predicted);
    if (!steady && $urandom_range(99) < 27) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(20, 1)) @(posedge clk);
    end
  endtask

  initial begin : receiver
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_OFF_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= 27);
      end
    end
  end

  always @(posedge clk) begin : check_results
    drive_cmd_t got, want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.drive = out_ch.drive;
      got.inner_setpoint = out_ch.inner_setpoint;
      if (pending_cmds.size() == 0) begin
        note_fault("result with none outstanding", '0, got);
      end else begin
        want = pending_cmds.pop_front();
        if (got.drive !== want.drive || got.inner_setpoint !== want.inner_setpoint)
          note_fault("result mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** cascaded_pid_motor_controller: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [2:0] cur_set;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.target_speed = '0;
    in_ch.measured_speed = '0;
    in_ch.target_angle = '0;
    in_ch.measured_angle = '0;
    in_ch.manual_drive = '0;
    ctl_cfg = '0;
    spd_prev_err = 0;
    spd_integ = 0;
    ang_prev_err = 0;
    ang_integ = 0;
    cur_set = 3'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].cfg_sel != cur_set) begin
        cur_set = dir_rows[i].cfg_sel;
        reconfigure(dir_cfgs[cur_set]);
      end
      send_tick(dir_rows[i].tick, dir_rows[i].known, dir_rows[i].cmd);
    end

    for (int p = 0; p < PHASES; p++) begin
      reconfigure(random_config());
      steady = (p == 3);
      if (p == 6) hold_req = 1'b1;
      repeat (TICKS_PER_PHASE) send_tick(random_tick(), 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    fail_count += pending_cmds.size();
    if (fail_count == 0) begin
      $display("** cascaded_pid_motor_controller: PASSED **");
    end else begin
      $display("** cascaded_pid_motor_controller: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/cvp_pkg.sv
design/cvp_if.sv
design/cvp_cfg_regs.sv
design/cvp_mac.sv
design/cascaded_pid_motor_controller.sv
bench/tb.sv
